@@ hdl/cbes_pkg.sv @@
// ----------------------------------------------------------------------------
// cbes_pkg: shared types for the cubic bezier easing solver
// Micro-operation codes, register selects, the micro-op table, controller
// states and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cbes_pkg;

  // arithmetic micro-operations
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_MUL3,
    OP_MUL6,
    OP_CLAMP,
    OP_LDY
  } uop_op_t;

  // working register selects
  typedef enum logic [3:0] {
    SEL_NONE,
    SEL_T,
    SEL_TW,
    SEL_U,
    SEL_M1,
    SEL_M3,
    SEL_M5,
    SEL_ACC,
    SEL_TMP,
    SEL_P1,
    SEL_P2,
    SEL_E,
    SEL_D,
    SEL_Q,
    SEL_ONE
  } sel_t;

  typedef struct packed {
    uop_op_t op;
    sel_t    dst;
    sel_t    sa;
    sel_t    sb;
  } uop_t;

  typedef logic [4:0] upc_t;

  // entry points of the micro-op table
  localparam upc_t UPC_CURVE      = 5'd0;
  localparam upc_t UPC_FINAL_END  = 5'd12;
  localparam upc_t UPC_CURVE_END  = 5'd13;
  localparam upc_t UPC_SLOPE      = 5'd14;
  localparam upc_t UPC_SLOPE_END  = 5'd23;
  localparam upc_t UPC_UPDATE     = 5'd24;
  localparam upc_t UPC_FINISH     = 5'd25;
  localparam upc_t UPC_FINISH_END = 5'd26;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_CTRL_X1,
    REG_CTRL_Y1,
    REG_CTRL_X2,
    REG_CTRL_Y2
  } reg_idx_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASSIFY,
    S_CURVE,
    S_CHECK,
    S_SLOPE,
    S_DCHECK,
    S_DIVIDE,
    S_UPDATE,
    S_FINISH,
    S_FINAL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic phase;
    uop_t uop;
    logic div_start;
  } dp_cmd_t;

  typedef struct packed {
    logic special;
    logic converged;
    logic d_zero;
    logic div_done;
  } dp_status_t;

  // micro-op table: curve, slope, newton update, clamp and y load
  function automatic uop_t uop_rom(input upc_t pc);
    uop_t u;
    unique case (pc)
      5'd0:    u = '{OP_SUB,   SEL_U,    SEL_ONE, SEL_T};
      5'd1:    u = '{OP_MUL,   SEL_M1,   SEL_U,   SEL_U};
      5'd2:    u = '{OP_MUL,   SEL_TMP,  SEL_M1,  SEL_T};
      5'd3:    u = '{OP_MUL,   SEL_TMP,  SEL_TMP, SEL_P1};
      5'd4:    u = '{OP_MUL3,  SEL_ACC,  SEL_TMP, SEL_NONE};
      5'd5:    u = '{OP_MUL,   SEL_M3,   SEL_U,   SEL_T};
      5'd6:    u = '{OP_MUL,   SEL_TMP,  SEL_M3,  SEL_T};
      5'd7:    u = '{OP_MUL,   SEL_TMP,  SEL_TMP, SEL_P2};
      5'd8:    u = '{OP_MUL3,  SEL_TMP,  SEL_TMP, SEL_NONE};
      5'd9:    u = '{OP_ADD,   SEL_ACC,  SEL_ACC, SEL_TMP};
      5'd10:   u = '{OP_MUL,   SEL_M5,   SEL_T,   SEL_T};
      5'd11:   u = '{OP_MUL,   SEL_TMP,  SEL_M5,  SEL_T};
      5'd12:   u = '{OP_ADD,   SEL_ACC,  SEL_ACC, SEL_TMP};
      5'd13:   u = '{OP_SUB,   SEL_E,    SEL_ACC, SEL_TW};
      5'd14:   u = '{OP_MUL,   SEL_TMP,  SEL_M1,  SEL_P1};
      5'd15:   u = '{OP_MUL3,  SEL_ACC,  SEL_TMP, SEL_NONE};
      5'd16:   u = '{OP_SUB,   SEL_TMP,  SEL_P2,  SEL_P1};
      5'd17:   u = '{OP_MUL,   SEL_TMP,  SEL_M3,  SEL_TMP};
      5'd18:   u = '{OP_MUL6,  SEL_TMP,  SEL_TMP, SEL_NONE};
      5'd19:   u = '{OP_ADD,   SEL_ACC,  SEL_ACC, SEL_TMP};
      5'd20:   u = '{OP_SUB,   SEL_TMP,  SEL_ONE, SEL_P2};
      5'd21:   u = '{OP_MUL,   SEL_TMP,  SEL_M5,  SEL_TMP};
      5'd22:   u = '{OP_MUL3,  SEL_TMP,  SEL_TMP, SEL_NONE};
      5'd23:   u = '{OP_ADD,   SEL_D,    SEL_ACC, SEL_TMP};
      5'd24:   u = '{OP_SUB,   SEL_T,    SEL_T,   SEL_Q};
      5'd25:   u = '{OP_CLAMP, SEL_T,    SEL_T,   SEL_NONE};
      5'd26:   u = '{OP_LDY,   SEL_NONE, SEL_NONE, SEL_NONE};
      default: u = '{OP_ADD,   SEL_NONE, SEL_NONE, SEL_NONE};
    endcase
    return u;
  endfunction

endpackage

@@ hdl/cubic_bezier_easing_solver.sv @@
// For a time at or below 0 or at or above 1 the controller goes from classify straight to done.
// Otherwise each newton step runs the curve and slope micro-ops on the shared multiplier and the
// divider at one quotient bit a cycle, then the update; the clamp and the final y evaluation
// follow before the done beat. One item at a time: busy stays high until the done beat, which
// the receiver cannot stall; the next start is taken in the cycle after it. Synchronous reset
// restores the control point registers and the controller state, not the datapath registers.
// ----------------------------------------------------------------------------
// cubic_bezier_easing_solver: css-style cubic bezier timing function
// Apb control point registers, controller and datapath for the newton solve.
// ----------------------------------------------------------------------------
module cubic_bezier_easing_solver #(
  parameter int ITERATIONS     = 16,
  parameter int PORT_FRAC_BITS = 16,
  parameter int WORK_FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  input  logic signed [17:0] progress_time,
  output logic               busy,
  output logic               done,
  output logic signed [17:0] eased_value
);
  import cbes_pkg::*;

  logic signed [17:0] ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2;
  logic signed [17:0] rd_sel;
  reg_idx_t           idx;
  dp_cmd_t            cmd;
  dp_status_t         status;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);

  // control point registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_x1 <= 18'sd16384;
      ctrl_y1 <= 18'sd6554;
      ctrl_x2 <= 18'sd16384;
      ctrl_y2 <= 18'sd65536;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        REG_CTRL_X1: ctrl_x1 <= pwdata[17:0];
        REG_CTRL_Y1: ctrl_y1 <= pwdata[17:0];
        REG_CTRL_X2: ctrl_x2 <= pwdata[17:0];
        REG_CTRL_Y2: ctrl_y2 <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (idx)
      REG_CTRL_X1: rd_sel = ctrl_x1;
      REG_CTRL_Y1: rd_sel = ctrl_y1;
      REG_CTRL_X2: rd_sel = ctrl_x2;
      REG_CTRL_Y2: rd_sel = ctrl_y2;
      default:     rd_sel = '0;
    endcase
    prdata = 32'(rd_sel);
  end

  cbes_ctrl #(
    .ITERATIONS(ITERATIONS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  cbes_dpath #(
    .PORT_FRAC_BITS(PORT_FRAC_BITS),
    .WORK_FRAC_BITS(WORK_FRAC_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .progress_time (progress_time),
    .ctrl_x1       (ctrl_x1),
    .ctrl_y1       (ctrl_y1),
    .ctrl_x2       (ctrl_x2),
    .ctrl_y2       (ctrl_y2),
    .status        (status),
    .eased_value   (eased_value)
  );

endmodule

@@ hdl/cbes_div.sv @@
// ----------------------------------------------------------------------------
// cbes_div: restoring divider for the newton step
// Signed work-format quotient, truncated toward zero, saturated when the
// integer part reaches eight; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbes_div #(
  parameter int WORK_FRAC_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [WORK_FRAC_BITS+3:0] num,
  input  logic signed [WORK_FRAC_BITS+3:0] den,
  output logic                             done,
  output logic signed [WORK_FRAC_BITS+3:0] quo
);
  import cbes_pkg::*;

  localparam int F  = WORK_FRAC_BITS;
  localparam int W  = F + 4;
  localparam int CW = $clog2(W);
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic          active;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-2:0]  nsh;
  logic [W-2:0]  qacc;
  logic          neg;

  logic [W-1:0]  ua;
  logic [W-1:0]  ud;
  logic          ovf;
  logic          sign_in;
  logic [W:0]    r2;
  logic [W:0]    diff;
  logic          ge;
  logic [W-1:0]  rnew;
  logic [W-2:0]  qnext;

  // operand magnitudes and overflow test
  always_comb begin
    ua      = num[W-1] ? W'(-num) : W'(num);
    ud      = den[W-1] ? W'(-den) : W'(den);
    ovf     = {3'b000, ua} >= {ud, 3'b000};
    sign_in = num[W-1] ^ den[W-1];
  end

  // one restoring step
  always_comb begin
    r2    = {rem, nsh[W-2]};
    diff  = r2 - {1'b0, ud};
    ge    = r2 >= {1'b0, ud};
    rnew  = ge ? diff[W-1:0] : r2[W-1:0];
    qnext = {qacc[W-3:0], ge};
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg <= sign_in;
        if (ovf) begin
          done <= 1'b1;
          quo  <= sign_in ? WMIN : WMAX;
        end else begin
          active <= 1'b1;
          cnt    <= CW'(W - 2);
          rem    <= ua >> 3;
          nsh    <= {ua[2:0], {F{1'b0}}};
          qacc   <= '0;
        end
      end else if (active) begin
        rem  <= rnew;
        nsh  <= nsh << 1;
        qacc <= qnext;
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
          quo    <= neg ? -$signed({1'b0, qnext}) : $signed({1'b0, qnext});
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/cbes_dpath.sv @@
// ----------------------------------------------------------------------------
// cbes_dpath: working registers and arithmetic of the easing solver
// Saturating add, subtract and scale, clamp, a rounding multiplier with a
// registered product, format conversion and the newton divider.
// ----------------------------------------------------------------------------
module cbes_dpath #(
  parameter int PORT_FRAC_BITS = 16,
  parameter int WORK_FRAC_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cbes_pkg::dp_cmd_t    cmd,
  input  logic signed [17:0]   progress_time,
  input  logic signed [17:0]   ctrl_x1,
  input  logic signed [17:0]   ctrl_y1,
  input  logic signed [17:0]   ctrl_x2,
  input  logic signed [17:0]   ctrl_y2,
  output cbes_pkg::dp_status_t status,
  output logic signed [17:0]   eased_value
);
  import cbes_pkg::*;

  localparam int F  = WORK_FRAC_BITS;
  localparam int P  = PORT_FRAC_BITS;
  localparam int W  = F + 4;
  localparam int XW = F + 18;
  localparam int YW = W + P;
  localparam int MW = 2 * W + 1 - F;

  localparam int TW_UP  = (F >= P) ? F - P : 0;
  localparam int TW_DN  = (F >= P) ? 1 : P - F;
  localparam int TP_DN  = (F > P) ? F - P : 1;
  localparam int TP_UP  = (F > P) ? 0 : P - F;
  localparam int EPS_SH = (F >= 20) ? F - 20 : 0;

  localparam logic signed [W-1:0]  WMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  WMIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [XW-1:0] WMAX_X = XW'(WMAX);
  localparam logic signed [XW-1:0] WMIN_X = XW'(WMIN);
  localparam logic signed [W-1:0]  ONE    = W'(1) <<< F;
  localparam logic signed [W-1:0]  EPS    = W'(1) <<< EPS_SH;
  localparam logic signed [31:0]   ONE_PORT = 32'sd1 <<< P;
  localparam logic signed [17:0]   ONE_OUT  = (P >= 17) ? 18'sh1FFFF : 18'(1 << P);
  localparam logic signed [YW-1:0] PMAX   = YW'(131071);
  localparam logic signed [YW-1:0] PMIN   = YW'(-131072);

  function automatic logic signed [W-1:0] sat_x(input logic signed [XW-1:0] v);
    if (v > WMAX_X) return WMAX;
    if (v < WMIN_X) return WMIN;
    return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] to_work(input logic signed [17:0] v);
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] m;
    logic signed [XW-1:0] r;
    x = XW'(v);
    if (F >= P) begin
      x = x <<< TW_UP;
    end else begin
      m = (x < 0) ? -x : x;
      r = (m + (XW'(1) <<< (TW_DN - 1))) >>> TW_DN;
      x = (v < 0) ? -r : r;
    end
    return sat_x(x);
  endfunction

  function automatic logic signed [17:0] to_port(input logic signed [W-1:0] v);
    logic signed [YW-1:0] x;
    logic signed [YW-1:0] m;
    logic signed [YW-1:0] r;
    x = YW'(v);
    if (F > P) begin
      m = (x < 0) ? -x : x;
      r = (m + (YW'(1) <<< (TP_DN - 1))) >>> TP_DN;
      x = (v < 0) ? -r : r;
    end else begin
      x = x <<< TP_UP;
    end
    if (x > PMAX) return 18'sh1FFFF;
    if (x < PMIN) return 18'sh20000;
    return x[17:0];
  endfunction

  // working registers
  logic signed [W-1:0] t, tw, u, m1, m3, m5, acc, tmp, p1, p2, e, d;
  logic signed [17:0]  time_raw;
  logic [2*W-1:0]      prod;
  logic                prod_neg;

  logic signed [W-1:0] a, b, alu, mul_res, quo;
  logic [W-1:0]        mag_a, mag_b;
  logic [2*W:0]        rsum;
  logic [MW-1:0]       mr;
  logic                pos_ovf, neg_ovf;
  logic                wr, div_done;
  logic                le0, ge1;

  // operand selection
  always_comb begin
    case (cmd.uop.sa)
      SEL_T:   a = t;
      SEL_TW:  a = tw;
      SEL_U:   a = u;
      SEL_M1:  a = m1;
      SEL_M3:  a = m3;
      SEL_M5:  a = m5;
      SEL_ACC: a = acc;
      SEL_TMP: a = tmp;
      SEL_P1:  a = p1;
      SEL_P2:  a = p2;
      SEL_E:   a = e;
      SEL_D:   a = d;
      SEL_Q:   a = quo;
      SEL_ONE: a = ONE;
      default: a = '0;
    endcase
    case (cmd.uop.sb)
      SEL_T:   b = t;
      SEL_TW:  b = tw;
      SEL_U:   b = u;
      SEL_M1:  b = m1;
      SEL_M3:  b = m3;
      SEL_M5:  b = m5;
      SEL_ACC: b = acc;
      SEL_TMP: b = tmp;
      SEL_P1:  b = p1;
      SEL_P2:  b = p2;
      SEL_E:   b = e;
      SEL_D:   b = d;
      SEL_Q:   b = quo;
      SEL_ONE: b = ONE;
      default: b = '0;
    endcase
  end

  // multiplier rounding and saturation
  always_comb begin
    mag_a   = a[W-1] ? W'(-a) : W'(a);
    mag_b   = b[W-1] ? W'(-b) : W'(b);
    rsum    = {1'b0, prod} + ((2 * W + 1)'(1) << (F - 1));
    mr      = rsum[2*W:F];
    pos_ovf = |mr[MW-1:W-1];
    neg_ovf = (|mr[MW-1:W]) || (mr[W-1] && (|mr[W-2:0]));
    if (prod_neg) mul_res = neg_ovf ? WMIN : -$signed(mr[W-1:0]);
    else          mul_res = pos_ovf ? WMAX : $signed(mr[W-1:0]);
  end

  // saturating alu
  always_comb begin
    case (cmd.uop.op)
      OP_ADD:   alu = sat_x(XW'(a) + XW'(b));
      OP_SUB:   alu = sat_x(XW'(a) - XW'(b));
      OP_MUL3:  alu = sat_x(XW'(a) + (XW'(a) <<< 1));
      OP_MUL6:  alu = sat_x((XW'(a) <<< 1) + (XW'(a) <<< 2));
      OP_MUL:   alu = mul_res;
      OP_CLAMP: alu = (a < 0) ? '0 : ((a > ONE) ? ONE : a);
      default:  alu = '0;
    endcase
    wr = cmd.exec && ((cmd.uop.op != OP_MUL) || cmd.phase);
  end

  // register writeback
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      time_raw <= progress_time;
      t        <= to_work(progress_time);
      tw       <= to_work(progress_time);
      p1       <= to_work(ctrl_x1);
      p2       <= to_work(ctrl_x2);
    end else if (cmd.exec && cmd.uop.op == OP_LDY) begin
      p1 <= to_work(ctrl_y1);
      p2 <= to_work(ctrl_y2);
    end else if (cmd.exec && cmd.uop.op == OP_MUL && !cmd.phase) begin
      prod     <= mag_a * mag_b;
      prod_neg <= a[W-1] ^ b[W-1];
    end else if (wr) begin
      case (cmd.uop.dst)
        SEL_T:   t   <= alu;
        SEL_U:   u   <= alu;
        SEL_M1:  m1  <= alu;
        SEL_M3:  m3  <= alu;
        SEL_M5:  m5  <= alu;
        SEL_ACC: acc <= alu;
        SEL_TMP: tmp <= alu;
        SEL_E:   e   <= alu;
        SEL_D:   d   <= alu;
        default: ;
      endcase
    end
  end

  // newton divider
  cbes_div #(
    .WORK_FRAC_BITS(WORK_FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (e),
    .den   (d),
    .done  (div_done),
    .quo   (quo)
  );

  // status and result
  always_comb begin
    le0              = time_raw <= 18'sd0;
    ge1              = 32'(time_raw) >= ONE_PORT;
    status.special   = le0 || ge1;
    status.converged = (e > -EPS) && (e < EPS);
    status.d_zero    = (d == '0);
    status.div_done  = div_done;
    if (le0)      eased_value = '0;
    else if (ge1) eased_value = ONE_OUT;
    else          eased_value = to_port(acc);
  end

endmodule

@@ hdl/cbes_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbes_ctrl: sequencer of the easing solver
// Walks the micro-op table for curve and slope, runs the newton loop with
// early exit, then evaluates y at the clamped parameter.
// ----------------------------------------------------------------------------
module cbes_ctrl #(
  parameter int ITERATIONS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  cbes_pkg::dp_status_t status,
  output cbes_pkg::dp_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);
  import cbes_pkg::*;

  localparam int ITER_W = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

  state_t            state, state_next;
  upc_t              pc, pc_next;
  logic              phase, phase_next;
  logic [ITER_W-1:0] iter, iter_next;

  uop_t uop;
  logic exec_st;
  logic step_done;
  upc_t end_pc;
  logic last;

  // current micro-op and step completion
  always_comb begin
    uop       = uop_rom(pc);
    exec_st   = (state == S_CURVE) || (state == S_SLOPE) || (state == S_UPDATE) ||
                (state == S_FINISH) || (state == S_FINAL);
    step_done = (uop.op != OP_MUL) || phase;
    unique case (state)
      S_SLOPE:  end_pc = UPC_SLOPE_END;
      S_UPDATE: end_pc = UPC_UPDATE;
      S_FINISH: end_pc = UPC_FINISH_END;
      S_FINAL:  end_pc = UPC_FINAL_END;
      default:  end_pc = UPC_CURVE_END;
    endcase
    last = step_done && (pc == end_pc);
  end

  // next state
  always_comb begin
    state_next = state;
    pc_next    = pc;
    phase_next = phase;
    iter_next  = iter;
    if (exec_st) begin
      if (step_done) begin
        phase_next = 1'b0;
        pc_next    = pc + 1'b1;
      end else begin
        phase_next = 1'b1;
      end
    end
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_CLASSIFY;
      end
      S_CLASSIFY: begin
        if (status.special) begin
          state_next = S_DONE;
        end else begin
          state_next = S_CURVE;
          pc_next    = UPC_CURVE;
          iter_next  = '0;
        end
      end
      S_CURVE: begin
        if (last) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.converged) begin
          state_next = S_FINISH;
          pc_next    = UPC_FINISH;
        end else begin
          state_next = S_SLOPE;
          pc_next    = UPC_SLOPE;
        end
      end
      S_SLOPE: begin
        if (last) state_next = S_DCHECK;
      end
      S_DCHECK: begin
        if (status.d_zero) begin
          state_next = S_FINISH;
          pc_next    = UPC_FINISH;
        end else begin
          state_next = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (status.div_done) begin
          state_next = S_UPDATE;
          pc_next    = UPC_UPDATE;
        end
      end
      S_UPDATE: begin
        if (iter == ITER_W'(ITERATIONS - 1)) begin
          state_next = S_FINISH;
          pc_next    = UPC_FINISH;
        end else begin
          state_next = S_CURVE;
          pc_next    = UPC_CURVE;
          iter_next  = iter + 1'b1;
        end
      end
      S_FINISH: begin
        if (last) begin
          state_next = S_FINAL;
          pc_next    = UPC_CURVE;
        end
      end
      S_FINAL: begin
        if (last) state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy          = (state != S_IDLE);
    done          = (state == S_DONE);
    cmd.load      = (state == S_IDLE) && start;
    cmd.exec      = exec_st;
    cmd.phase     = phase;
    cmd.uop       = uop;
    cmd.div_start = (state == S_DCHECK) && !status.d_zero;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= UPC_CURVE;
      phase <= 1'b0;
      iter  <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      phase <= phase_next;
      iter  <= iter_next;
    end
  end

  // divider is never started on a zero slope
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.d_zero)
    else $error("divider started with zero slope");

  // a finished quotient always leads to the update step
  a_div_update: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVIDE && status.div_done) |=> (state == S_UPDATE))
    else $error("quotient not taken into update");

  // second multiply phase only inside a multiply micro-op
  a_phase_mul: assert property (@(posedge clk) disable iff (rst)
    phase |-> (exec_st && uop.op == OP_MUL))
    else $error("multiply phase outside multiply");

endmodule
